>>> rtl/core/sgf_pkg.sv
// ----------------------------------------------------------------------------
// sgf_pkg
// Shared types and constants of the spring guidance force filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sgf_pkg;

  localparam int POS_W      = 24;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = 26;
  localparam int STIFF_W    = 16;
  localparam int FORCE_W    = 20;
  localparam int PROD_W     = DIST_W + STIFF_W;
  localparam int FORCE_SH   = 8;
  localparam int SQRT_STEPS = 25;
  localparam int CFG_W      = 26;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE = 2'd2;

  localparam logic [STIFF_W-1:0] STIFFNESS_RST = 16'd655;
  localparam logic [DIST_W-1:0]  DEAD_ZONE_RST = 26'd7680;
  localparam logic [FORCE_W-1:0] MAX_FORCE_RST = 20'd458752;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [SQ_W-1:0]         sq_t;

  typedef struct packed {
    logic [STIFF_W-1:0] stiffness;
    logic [DIST_W-1:0]  dead_zone;
    logic [FORCE_W-1:0] max_force;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sgf_front.sv
// ----------------------------------------------------------------------------
// sgf_front
// Accepts a position transaction and forms the sum of squared axis distances
// with one shared multiplier, then pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgf_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sgf_pkg::pos_t  in_effector_x,
  input  wire sgf_pkg::pos_t  in_effector_y,
  input  wire sgf_pkg::pos_t  in_effector_z,
  input  wire sgf_pkg::pos_t  in_goal_x,
  input  wire sgf_pkg::pos_t  in_goal_y,
  input  wire sgf_pkg::pos_t  in_goal_z,
  input  wire logic           q_full,
  output logic                q_push,
  output sgf_pkg::sq_t        q_wdata
);
  import sgf_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ACC  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [1:0] STEP_LAST = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [SQ_W-1:0]   sq_r, acc_r, acc_nxt;
  logic [DIFF_W-1:0] op;
  logic [SQ_W-1:0]   sq;

  function automatic logic [DIFF_W-1:0] abs_diff(pos_t a, pos_t b);
    logic signed [DIFF_W-1:0] d;
    begin
      d = DIFF_W'(a) - DIFF_W'(b);
      abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    end
  endfunction

  always_comb begin
    case (step_r)
      2'd0:    op = dx_r;
      2'd1:    op = dy_r;
      2'd2:    op = dz_r;
      default: op = '0;
    endcase
  end

  assign sq = op * op;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_ACC;
          step_nxt  = '0;
          acc_nxt   = '0;
        end
      end
      F_ACC: begin
        if (step_r != 2'd0) begin
          acc_nxt = acc_r + sq_r;
        end
        step_nxt = step_r + 2'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_wdata  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq;
    if (in_valid && in_ready) begin
      dx_r <= abs_diff(in_goal_x, in_effector_x);
      dy_r <= abs_diff(in_goal_y, in_effector_y);
      dz_r <= abs_diff(in_goal_z, in_effector_z);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sgf_queue.sv
// ----------------------------------------------------------------------------
// sgf_queue
// Two-entry queue of squared-distance sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sgf_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire sgf_pkg::sq_t wdata,
  input  wire logic         pop,
  output sgf_pkg::sq_t      rdata,
  output sgf_pkg::q_stat_t  stat
);
  import sgf_pkg::*;

  logic [SQ_W-1:0] slot_q [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = slot_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_q[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sgf_back.sv
// ----------------------------------------------------------------------------
// sgf_back
// Bit-serial square root, spring force with dead zone and saturation, and
// moving-average history with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgf_back #(
  parameter int WINDOW = 50
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sgf_pkg::cfg_t                 cfg,
  input  wire sgf_pkg::q_stat_t              q_stat,
  input  wire sgf_pkg::sq_t                  q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sgf_pkg::FORCE_W-1:0]        out_filtered_force,
  output logic [sgf_pkg::FORCE_W-1:0]        out_raw_force,
  output logic [sgf_pkg::DIST_W-1:0]         out_distance
);
  import sgf_pkg::*;

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = FORCE_W + $clog2(WINDOW + 1);
  localparam int DIV_SH  = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int QP_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [4:0]         ITER_LAST = 5'(SQRT_STEPS - 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQRT = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_SAT  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]              state_r;
  logic [SQ_W-1:0]         rem_r, res_r, bit_r;
  logic [SQ_W-1:0]         trial;
  logic [4:0]              iter_r;
  logic [DIST_W-1:0]       dist_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    zone_r;
  logic [FORCE_W-1:0]      old_r, force_r, force_nxt;
  logic                    old_vld_r;
  logic [SUM_W-1:0]        sum_r;
  logic [QP_W-1:0]         quo_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [WINDOW-1:0]       hist_vld_r;
  logic [FORCE_W-1:0]      hist_mem [WINDOW];
  logic [PROD_W-FORCE_SH-1:0] scaled;
  logic                    out_load;
  logic                    hist_we;
  logic [FORCE_W-1:0]      old_val;

  assign trial    = res_r + bit_r;
  assign scaled   = prod_r[PROD_W-1:FORCE_SH];
  assign old_val  = old_vld_r ? old_r : '0;
  assign q_pop    = (state_r == B_IDLE) && !q_stat.empty;
  assign out_load = (state_r == B_OUT) && (!out_valid || out_ready);
  assign hist_we  = (state_r == B_SAT);

  always_comb begin
    if (zone_r) begin
      force_nxt = '0;
    end else if (scaled > (PROD_W-FORCE_SH)'(cfg.max_force)) begin
      force_nxt = cfg.max_force;
    end else begin
      force_nxt = scaled[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      iter_r     <= '0;
      slot_r     <= '0;
      sum_r      <= '0;
      hist_vld_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            iter_r  <= '0;
            state_r <= B_SQRT;
          end
        end
        B_SQRT: begin
          iter_r <= iter_r + 5'd1;
          if (iter_r == ITER_LAST) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: state_r <= B_SAT;
        B_SAT: begin
          sum_r              <= sum_r - SUM_W'(old_val) + SUM_W'(force_nxt);
          hist_vld_r[slot_r] <= 1'b1;
          slot_r             <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
          state_r            <= B_DIV;
        end
        B_DIV: state_r <= B_OUT;
        B_OUT: begin
          if (out_load) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // square root datapath, force and average
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        rem_r     <= q_rdata;
        res_r     <= '0;
        bit_r     <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
        old_r     <= hist_mem[slot_r];
        old_vld_r <= hist_vld_r[slot_r];
      end
      B_SQRT: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      B_MUL: begin
        dist_r <= res_r[DIST_W-1:0];
        prod_r <= res_r[DIST_W-1:0] * cfg.stiffness;
        zone_r <= (res_r[DIST_W-1:0] < cfg.dead_zone);
      end
      B_SAT: force_r <= force_nxt;
      B_DIV: quo_r <= sum_r * RECIP;
      default: begin
      end
    endcase
    if (out_load) begin
      out_filtered_force <= quo_r[DIV_SH +: FORCE_W];
      out_raw_force      <= force_r;
      out_distance       <= dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[slot_r] <= force_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/spring_guidance_force_filter.sv
// ----------------------------------------------------------------------------
// spring_guidance_force_filter
// Saturated spring guidance force with moving-average filter.
// ----------------------------------------------------------------------------
// Each transaction carries effector and goal positions in 1/256 mm. The block
// returns the floor Euclidean distance, the spring force (zero inside the dead
// zone, saturated at max_force) and its average over the last WINDOW
// transactions. The front forms the sum of squares, a two-entry queue follows,
// and the back handles one transaction at a time in its steps (one load, 25
// bit-serial square root steps, multiply, saturate, divide, output register),
// taking the next only after the result is loaded into the output register, so
// throughput is set by the square root loop. The history starts at zero after
// reset through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_guidance_force_filter #(
  parameter int WINDOW = 50
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sgf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sgf_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sgf_pkg::pos_t                   in_effector_x,
  input  wire sgf_pkg::pos_t                   in_effector_y,
  input  wire sgf_pkg::pos_t                   in_effector_z,
  input  wire sgf_pkg::pos_t                   in_goal_x,
  input  wire sgf_pkg::pos_t                   in_goal_y,
  input  wire sgf_pkg::pos_t                   in_goal_z,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sgf_pkg::FORCE_W-1:0]          out_filtered_force,
  output logic [sgf_pkg::FORCE_W-1:0]          out_raw_force,
  output logic [sgf_pkg::DIST_W-1:0]           out_distance
);
  import sgf_pkg::*;

  cfg_t    cfg_r;
  q_stat_t q_stat;
  logic    q_push, q_pop;
  sq_t     q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness <= STIFFNESS_RST;
      cfg_r.dead_zone <= DEAD_ZONE_RST;
      cfg_r.max_force <= MAX_FORCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STIFFNESS: cfg_r.stiffness <= cfg_wdata[STIFF_W-1:0];
        CFG_DEAD_ZONE: cfg_r.dead_zone <= cfg_wdata[DIST_W-1:0];
        CFG_MAX_FORCE: cfg_r.max_force <= cfg_wdata[FORCE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sgf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_effector_x (in_effector_x),
    .in_effector_y (in_effector_y),
    .in_effector_z (in_effector_z),
    .in_goal_x     (in_goal_x),
    .in_goal_y     (in_goal_y),
    .in_goal_z     (in_goal_z),
    .q_full        (q_stat.full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  sgf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sgf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_stat             (q_stat),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_force (out_filtered_force),
    .out_raw_force      (out_raw_force),
    .out_distance       (out_distance)
  );

endmodule

`default_nettype wire
